>>> rtl/lbpg_pkg.sv
// ----------------------------------------------------------------------------
// lbpg_pkg: shared types and constants for the heartbeat LED controller
// Holds mode codes, request kinds, register indexes and reset values.
// ----------------------------------------------------------------------------
package lbpg_pkg;

    localparam int CFG_W           = 16;
    localparam int CFG_ADDR_W      = 2;
    localparam int TIMER_BITS_DEF  = 16;

    localparam logic [CFG_W-1:0] SHORT_PERIOD_RST = 16'd100;
    localparam logic [CFG_W-1:0] ASYM_OFF_RST     = 16'd900;
    localparam logic [CFG_W-1:0] SLOW_PERIOD_RST  = 16'd500;
    localparam logic [CFG_W-1:0] PATTERN_GAP_RST  = 16'd300;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SHORT_PERIOD = 2'd0,
        REG_ASYM_OFF     = 2'd1,
        REG_SLOW_PERIOD  = 2'd2,
        REG_PATTERN_GAP  = 2'd3
    } reg_idx_t;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_ON     = 3'd1,
        MODE_ASYM   = 3'd2,
        MODE_FAST   = 3'd3,
        MODE_SLOW   = 3'd4,
        MODE_UPDATE = 3'd5
    } mode_t;

    typedef struct packed {
        logic [CFG_W-1:0] short_period;
        logic [CFG_W-1:0] asym_off;
        logic [CFG_W-1:0] slow_period;
        logic [CFG_W-1:0] pattern_gap;
    } cfg_t;

    typedef struct packed {
        logic       op;
        logic [2:0] req;
    } item_t;

    typedef struct packed {
        logic       led_on;
        logic [2:0] active_mode;
        logic       change_pending;
    } res_t;

endpackage

>>> rtl/lbpg_cfg_regs.sv
// ----------------------------------------------------------------------------
// lbpg_cfg_regs: configuration register file
// Four 16-bit period registers, written through a plain write port.
// ----------------------------------------------------------------------------
module lbpg_cfg_regs
    import lbpg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_period <= SHORT_PERIOD_RST;
            cfg_reg.asym_off     <= ASYM_OFF_RST;
            cfg_reg.slow_period  <= SLOW_PERIOD_RST;
            cfg_reg.pattern_gap  <= PATTERN_GAP_RST;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_SHORT_PERIOD: cfg_reg.short_period <= cfg_wr_data;
                REG_ASYM_OFF:     cfg_reg.asym_off     <= cfg_wr_data;
                REG_SLOW_PERIOD:  cfg_reg.slow_period  <= cfg_wr_data;
                REG_PATTERN_GAP:  cfg_reg.pattern_gap  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/lbpg_core.sv
// ----------------------------------------------------------------------------
// lbpg_core: mode, countdown and LED state
// Applies one tick or mode request per step and gives the state that results from it.
// ----------------------------------------------------------------------------
module lbpg_core
    import lbpg_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  step,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    mode_t                 cur_mode_reg,  cur_mode_next;
    mode_t                 pend_mode_reg, pend_mode_next;
    logic                  pend_reg,      pend_next;
    logic [TIMER_BITS-1:0] rem_reg,       rem_next;
    logic                  led_reg,       led_next;
    logic [1:0]            phase_reg,     phase_next;

    logic [TIMER_BITS-1:0] rem_dec;
    logic                  expired;
    logic                  load_en;
    logic [CFG_W-1:0]      load_src;
    logic [TIMER_BITS-1:0] load_val;

    // saturate a loaded length to the countdown width
    generate
        if (TIMER_BITS >= CFG_W) begin : g_wide
            assign load_val = TIMER_BITS'(load_src);
        end else begin : g_narrow
            assign load_val = ((load_src >> TIMER_BITS) != '0) ? '1
                                                                : load_src[TIMER_BITS-1:0];
        end
    endgenerate

    assign rem_dec = (rem_reg != '0) ? rem_reg - TIMER_BITS'(1) : rem_reg;
    assign expired = (rem_dec == '0);

    always_comb begin
        cur_mode_next  = cur_mode_reg;
        pend_mode_next = pend_mode_reg;
        pend_next      = pend_reg;
        rem_next       = rem_reg;
        led_next       = led_reg;
        phase_next     = phase_reg;
        load_en        = 1'b0;
        load_src       = cfg.short_period;

        if (item.op == OP_REQUEST) begin
            // undefined codes fall back to off
            pend_mode_next = (item.req <= 3'(MODE_UPDATE)) ? mode_t'(item.req) : MODE_OFF;
            pend_next      = 1'b1;
        end else begin
            rem_next = rem_dec;
            if (pend_reg && expired) begin
                cur_mode_next = pend_mode_reg;
                pend_next     = 1'b0;
            end
            case (cur_mode_next)
                MODE_ON: begin
                    led_next = 1'b1;
                end
                MODE_ASYM: begin
                    if (expired) begin
                        load_en  = 1'b1;
                        load_src = led_reg ? cfg.asym_off : cfg.short_period;
                        led_next = !led_reg;
                    end
                end
                MODE_FAST: begin
                    if (expired) begin
                        load_en  = 1'b1;
                        load_src = cfg.short_period;
                        led_next = !led_reg;
                    end
                end
                MODE_SLOW: begin
                    if (expired) begin
                        load_en  = 1'b1;
                        load_src = cfg.slow_period;
                        led_next = !led_reg;
                    end
                end
                MODE_UPDATE: begin
                    // odd phases lit
                    led_next = phase_reg[0];
                    if (expired) begin
                        load_en = 1'b1;
                        if (phase_reg == 2'd3) begin
                            load_src   = cfg.pattern_gap;
                            phase_next = 2'd0;
                        end else begin
                            load_src   = cfg.short_period;
                            phase_next = phase_reg + 2'd1;
                        end
                    end
                end
                default: begin
                    led_next = 1'b0;
                end
            endcase
            if (load_en) begin
                rem_next = load_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_mode_reg  <= MODE_OFF;
            pend_mode_reg <= MODE_OFF;
            pend_reg      <= 1'b0;
            rem_reg       <= '0;
            led_reg       <= 1'b0;
            phase_reg     <= 2'd0;
        end else if (step) begin
            cur_mode_reg  <= cur_mode_next;
            pend_mode_reg <= pend_mode_next;
            pend_reg      <= pend_next;
            rem_reg       <= rem_next;
            led_reg       <= led_next;
            phase_reg     <= phase_next;
        end
    end

    assign res.led_on         = led_next;
    assign res.active_mode    = 3'(cur_mode_next);
    assign res.change_pending = pend_next;

    a_pend_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.op == OP_TICK && pend_reg && (rem_reg == '0 || rem_reg == TIMER_BITS'(1))
        |=> !pend_reg && cur_mode_reg == $past(pend_mode_reg))
        else $error("pending mode not taken on expiry");

    a_req_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.op == OP_REQUEST |=> pend_reg)
        else $error("request did not set pending");

    a_req_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.op == OP_REQUEST
        |=> $stable(cur_mode_reg) && $stable(led_reg) && $stable(rem_reg) && $stable(phase_reg))
        else $error("request moved the LED state");

    a_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.op == OP_TICK && cur_mode_reg == MODE_OFF && !pend_reg |=> !led_reg)
        else $error("LED lit in off mode");

endmodule

>>> rtl/led_blink_pattern_generator.sv
// A request accepted into the input register reaches m_tvalid from the result register.
// Throughput: one request per cycle; the input register and the state update with the
// result register form two overlapped stages; m_tready low with m_tvalid set holds both.
// Reset: aresetn low at a clock edge clears the mode, countdown, LED and pipeline valids
// and restores the four period registers to 100, 900, 500 and 300 ms.
// ----------------------------------------------------------------------------
// led_blink_pattern_generator: heartbeat LED controller top level
// Takes tick and mode requests on a stream port and returns the LED state.
// ----------------------------------------------------------------------------
module led_blink_pattern_generator
    import lbpg_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [2:0] mode_request, [7:3] zero
    input  logic                  s_tuser,   // [0] operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] led_on, [1] pin_level,
                                             // [4:2] active_mode, [5] change_pending
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wr_data
);

    cfg_t  cfg;
    item_t in_item_reg;
    logic  in_valid_reg;
    res_t  res;
    res_t  out_res_reg;
    logic  out_valid_reg;
    logic  out_ready;
    logic  step;

    assign out_ready = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    lbpg_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    lbpg_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_item_reg.op  <= s_tuser;
            in_item_reg.req <= s_tdata[2:0];
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
        if (step) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.change_pending, out_res_reg.active_mode,
                       !out_res_reg.led_on, out_res_reg.led_on};

endmodule
